// File: sv/pcc_pkg.sv
package pcc_pkg;

   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_CLAMP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_CLAMP   = 3'd4;

   localparam logic CMD_STEP  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam int unsigned FRAC_W = 16;
   localparam int unsigned DVD_W  = 32 + FRAC_W;

   // two quotient bits per cycle
   localparam int unsigned DIV_STEPS = DVD_W / 2;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MP,
      ST_MINC,
      ST_MD,
      ST_ACC,
      ST_MI,
      ST_TI,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // product >>> 16 with saturation to 32 bits
   function automatic logic signed [31:0] sat_prod(input logic signed [65:0] prod);
      logic [49:0] sh;
      sh = prod[65:FRAC_W];
      if ((&sh[49:31]) || !(|sh[49:31])) begin
         return $signed(sh[31:0]);
      end
      return sh[49] ? Q_MIN : Q_MAX;
   endfunction

   function automatic logic signed [31:0] sat_sum(input logic signed [33:0] x);
      if ((&x[33:31]) || !(|x[33:31])) begin
         return $signed(x[31:0]);
      end
      return x[33] ? Q_MIN : Q_MAX;
   endfunction

   function automatic logic signed [31:0] clamp_mag(input logic signed [31:0] x,
                                                    input logic [30:0] lim);
      logic signed [31:0] lp;
      logic signed [31:0] ln;
      lp = $signed({1'b0, lim});
      ln = -lp;
      if (lim == '0) begin
         return x;
      end
      if (x > lp) begin
         return lp;
      end
      if (x < ln) begin
         return ln;
      end
      return x;
   endfunction

endpackage

// File: sv/pcc_mul.sv
module pcc_mul
   import pcc_pkg::*;
(
   input  logic               clock,
   input  logic signed [32:0] op_a,
   input  logic signed [32:0] op_b,
   output logic signed [65:0] prod
);

   logic signed [65:0] prod_ff;
   logic signed [65:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: sv/pcc_div.sv
module pcc_div
   import pcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic [31:0]        den,
   output div_stat_type       stat,
   output logic signed [31:0] quo
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [31:0]          den_ff, den_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [31:0]          rem_ff, rem_in;
   logic signed [31:0]   quo_ff, quo_in;

   logic [32:0]      r1, r1n, r2, r2n;
   logic             ge1, ge2;
   logic [DVD_W-1:0] d1, d2;
   logic [31:0]      mag;

   // two restoring steps per cycle; quotient bits shift in at the bottom
   always_comb begin
      r1  = {rem_ff, dvd_ff[DVD_W-1]};
      ge1 = r1 >= {1'b0, den_ff};
      r1n = ge1 ? r1 - {1'b0, den_ff} : r1;
      d1  = {dvd_ff[DVD_W-2:0], ge1};
      r2  = {r1n[31:0], d1[DVD_W-1]};
      ge2 = r2 >= {1'b0, den_ff};
      r2n = ge2 ? r2 - {1'b0, den_ff} : r2;
      d2  = {d1[DVD_W-2:0], ge2};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      mag     = num[31] ? 32'(-num) : 32'(num);
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         neg_in  = num[31];
         den_in  = den;
         dvd_in  = {mag, {FRAC_W{1'b0}}};
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = d2;
         rem_in = r2n[31:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               quo_in = (|d2[DVD_W-1:31]) ? Q_MAX : $signed(d2[31:0]);
            end else begin
               quo_in = ((|d2[DVD_W-1:32]) || (d2[31] && (|d2[30:0]))) ?
                        Q_MIN : $signed(-d2[31:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      den_ff <= den_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = quo_ff;

endmodule

// File: sv/pid_controller_clamped.sv
// Clamped PID controller, signed Q16.16.
// req channel: req_tdata carries err_sample and time_step, req_tuser the
// command (step or clear). Each transfer gives exactly one rsp transfer
// carrying drive. csr port writes gains and limits, one register per
// cycle that csr_we is high; unused indexes are ignored.
// One item at a time: req_tready is high only while the sequencer is idle.
// A control step runs the multiplier states and then waits on the
// radix-4 divider for the derivative term; with time_step of zero the
// divider is skipped. A clear goes straight to the output state.
// The next request can transfer in the same cycle that rsp_tvalid rises.
// The four products share one registered 33x33 multiplier, one per cycle.
// The result sits in an output register; the next request is taken while
// it waits. If rsp_tready stays low the sequencer holds the following
// result until the register frees, and no result is lost.
// Synchronous reset clears gains, limits, integral and previous error,
// and drops any result not yet transferred.
module pid_controller_clamped
   import pcc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // [31:0] err_sample, [63:32] time_step
   input  logic                 req_tuser,   // [0] command
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [31:0] drive
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   state_type state_ff, state_in;

   logic signed [31:0] gain_p_ff, gain_p_in;
   logic signed [31:0] gain_i_ff, gain_i_in;
   logic signed [31:0] gain_d_ff, gain_d_in;
   logic [30:0]        integ_clamp_ff, integ_clamp_in;
   logic [30:0]        out_clamp_ff, out_clamp_in;

   logic signed [31:0] accum_ff, accum_in;
   logic signed [31:0] last_err_ff, last_err_in;
   logic signed [31:0] err_ff, err_in;
   logic [31:0]        dt_ff, dt_in;
   logic signed [31:0] diff_ff, diff_in;
   logic signed [31:0] p_ff, p_in;
   logic signed [31:0] inc_ff, inc_in;
   logic signed [31:0] i_ff, i_in;
   logic signed [31:0] num_ff, num_in;
   logic signed [31:0] d_ff, d_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] drive_ff, drive_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_prod;
   logic               div_start;
   div_stat_type       div_stat;
   logic signed [31:0] div_quo;
   logic               req_xfer;
   logic signed [31:0] req_err;

   pcc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   pcc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (dt_ff),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign req_err    = $signed(req_tdata[31:0]);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;

   // config registers
   always_comb begin
      gain_p_in      = gain_p_ff;
      gain_i_in      = gain_i_ff;
      gain_d_in      = gain_d_ff;
      integ_clamp_in = integ_clamp_ff;
      out_clamp_in   = out_clamp_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_GAIN_P:      gain_p_in      = $signed(csr_wdata);
            REG_GAIN_I:      gain_i_in      = $signed(csr_wdata);
            REG_GAIN_D:      gain_d_in      = $signed(csr_wdata);
            REG_INTEG_CLAMP: integ_clamp_in = csr_wdata[30:0];
            REG_OUT_CLAMP:   out_clamp_in   = csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      accum_in     = accum_ff;
      last_err_in  = last_err_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      diff_in      = diff_ff;
      p_in         = p_ff;
      inc_in       = inc_ff;
      i_in         = i_ff;
      num_in       = num_ff;
      d_in         = d_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      drive_in     = drive_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               dt_in   = req_tdata[63:32];
               diff_in = sat_sum(34'(req_err) - 34'(last_err_ff));
               if (req_tuser == CMD_CLEAR) begin
                  err_in   = '0;
                  accum_in = '0;
                  p_in     = '0;
                  i_in     = '0;
                  d_in     = '0;
                  state_in = ST_OUT;
               end else begin
                  err_in   = req_err;
                  state_in = ST_MP;
               end
            end
         end
         ST_MP: begin
            mul_a    = 33'(gain_p_ff);
            mul_b    = 33'(err_ff);
            state_in = ST_MINC;
         end
         ST_MINC: begin
            p_in     = sat_prod(mul_prod);
            mul_a    = 33'(err_ff);
            mul_b    = $signed({1'b0, dt_ff});
            state_in = ST_MD;
         end
         ST_MD: begin
            inc_in   = sat_prod(mul_prod);
            mul_a    = 33'(gain_d_ff);
            mul_b    = 33'(diff_ff);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            num_in   = sat_prod(mul_prod);
            accum_in = clamp_mag(sat_sum(34'(accum_ff) + 34'(inc_ff)), integ_clamp_ff);
            state_in = ST_MI;
         end
         ST_MI: begin
            mul_a     = 33'(gain_i_ff);
            mul_b     = 33'(accum_ff);
            div_start = (dt_ff != '0);
            state_in  = ST_TI;
         end
         ST_TI: begin
            i_in     = sat_prod(mul_prod);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (dt_ff == '0) begin
               d_in     = '0;
               state_in = ST_OUT;
            end else if (div_stat.done) begin
               d_in     = div_quo;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               drive_in     = clamp_mag(sat_sum(34'(p_ff) + 34'(i_ff) + 34'(d_ff)),
                                        out_clamp_ff);
               rsp_valid_in = 1'b1;
               last_err_in  = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         gain_d_ff      <= '0;
         integ_clamp_ff <= '0;
         out_clamp_ff   <= '0;
         accum_ff       <= '0;
         last_err_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         gain_p_ff      <= gain_p_in;
         gain_i_ff      <= gain_i_in;
         gain_d_ff      <= gain_d_in;
         integ_clamp_ff <= integ_clamp_in;
         out_clamp_ff   <= out_clamp_in;
         accum_ff       <= accum_in;
         last_err_ff    <= last_err_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      err_ff   <= err_in;
      dt_ff    <= dt_in;
      diff_ff  <= diff_in;
      p_ff     <= p_in;
      inc_ff   <= inc_in;
      i_ff     <= i_in;
      num_ff   <= num_in;
      d_ff     <= d_in;
      drive_ff <= drive_in;
   end

`ifndef SYNTHESIS
   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_stat.busy)
      else $error("divider busy while sequencer idle");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");

   a_div_done_leaves: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && div_stat.done |=> state_ff == ST_OUT)
      else $error("sequencer missed divider completion");

   a_out_div_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> !div_stat.busy)
      else $error("divider still busy at output");
`endif

endmodule

// File: verif/pid_controller_clamped_test.sv
class pid_scoreboard;
   int              kp;
   int              ki;
   int              kd;
   longint          integ_lim;
   longint          out_lim;
   int              integ;
   int              prev_err;
   int              expected_drive[$];
   int              mismatches;

   function new();
      kp = 0;
      ki = 0;
      kd = 0;
      integ_lim = 0;
      out_lim = 0;
      integ = 0;
      prev_err = 0;
      mismatches = 0;
   endfunction

   static function int sat(longint x);
      if (x > longint'(pcc_pkg::Q_MAX)) begin
         return pcc_pkg::Q_MAX;
      end
      if (x < longint'(pcc_pkg::Q_MIN)) begin
         return pcc_pkg::Q_MIN;
      end
      return int'(x);
   endfunction

   // magnitude limit, zero means no limit
   static function int clip(int x, longint lim);
      if (lim == 0) begin
         return x;
      end
      if (longint'(x) > lim) begin
         return int'(lim);
      end
      if (longint'(x) < -lim) begin
         return int'(-lim);
      end
      return x;
   endfunction

   function void write_reg(logic [pcc_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
         pcc_pkg::REG_GAIN_P: begin
            kp = int'(val);
         end
         pcc_pkg::REG_GAIN_I: begin
            ki = int'(val);
         end
         pcc_pkg::REG_GAIN_D: begin
            kd = int'(val);
         end
         pcc_pkg::REG_INTEG_CLAMP: begin
            integ_lim = longint'({33'h0, val[30:0]});
         end
         pcc_pkg::REG_OUT_CLAMP: begin
            out_lim = longint'({33'h0, val[30:0]});
         end
         default: begin
         end
      endcase
   endfunction

   function void note_request(logic cmd, logic [31:0] err_bits, logic [31:0] dt_bits);
      int     err;
      longint dt;
      int     p;
      int     i;
      int     d;
      int     diff;
      int     num;
      err = int'(err_bits);
      dt = longint'({32'h0, dt_bits});
      if (cmd == pcc_pkg::CMD_CLEAR) begin
         integ = 0;
         prev_err = 0;
         expected_drive.push_back(0);
         return;
      end
      p = sat((longint'(kp) * longint'(err)) >>> 16);
      integ = sat(longint'(integ) + longint'(sat((longint'(err) * dt) >>> 16)));
      integ = clip(integ, integ_lim);
      i = sat((longint'(ki) * longint'(integ)) >>> 16);
      d = 0;
      if (dt != 0) begin
         diff = sat(longint'(err) - longint'(prev_err));
         num = sat((longint'(kd) * longint'(diff)) >>> 16);
         // signed division truncates toward zero
         d = sat((longint'(num) * 65536) / dt);
      end
      prev_err = err;
      expected_drive.push_back(clip(sat(longint'(p) + longint'(i) + longint'(d)), out_lim));
   endfunction

   function void check_drive(logic [31:0] got);
      int want;
      if (expected_drive.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected drive transfer 0x%08h, nothing pending", got);
         end
         return;
      end
      want = expected_drive.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("drive mismatch: expected 0x%08h (%0d) got 0x%08h",
                     want, want, got);
         end
      end
   endfunction

   function int pending();
      return expected_drive.size();
   endfunction
endclass

module pid_controller_clamped_test;
   import pcc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RAND_PHASES    = 8;
   localparam int PHASE_ITEMS    = 100;
   localparam int LONG_HOLD      = 400;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [63:0]          req_tdata;   // [31:0] err_sample, [63:32] time_step
   logic                 req_tuser;   // [0] command
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [31:0]          rsp_tdata;   // [31:0] drive
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   pid_scoreboard sb = new();

   bit send_gaps;
   bit recv_gaps;
   bit long_hold_due;
   bit long_hold_taken;
   int stalled_cycles;

   pid_controller_clamped dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_drive(rsp_tdata);
      end
   end

   // watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side backpressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_due && !long_hold_taken) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_taken = 1'b1;
         end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   task automatic send_item(input logic cmd, input logic [31:0] err, input logic [31:0] dt);
      @(negedge clock);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = cmd;
      req_tdata = {dt, err};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, err, dt);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic configure(input logic [31:0] gp, input logic [31:0] gi, input logic [31:0] gd,
                            input logic [30:0] ilim, input logic [30:0] olim);
      put_reg(REG_GAIN_P, gp);
      put_reg(REG_GAIN_I, gi);
      put_reg(REG_GAIN_D, gd);
      put_reg(REG_INTEG_CLAMP, {1'b0, ilim});
      put_reg(REG_OUT_CLAMP, {1'b0, olim});
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // stop offering and wait for every pending drive value
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_err();
      case ($urandom_range(0, 9))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         3, 4, 5: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_dt();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: return $urandom_range(1, 255);
         3, 4, 5, 6: return $urandom_range(1, 32'h0002_0000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_gain();
      case ($urandom_range(0, 9))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return 32'h0;
         3, 4, 5, 6: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [30:0] rand_limit();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 7))
         0, 1: return 31'h0;
         2: return 31'h7fff_ffff;
         3: return 31'h1;
         4, 5: return 31'($urandom_range(1, 32'h0040_0000));
         default: return r[30:0];
      endcase
   endfunction

   initial begin
      logic [CSR_IDX_W-1:0] idx;
      logic                 cmd;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = CMD_STEP;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      long_hold_due = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // registers still at their reset values: output must be zero
      send_item(CMD_STEP, 32'h0001_0000, 32'h0001_0000);
      wait_drained();

      configure(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 31'h0, 31'h0);
      // unused indexes must leave the gains alone
      idx = REG_OUT_CLAMP;
      do begin
         idx++;
         put_reg(idx, $urandom());
      end while (idx != '1);
      @(negedge clock);
      csr_we = 1'b0;

      send_item(CMD_CLEAR, $urandom(), $urandom());
      send_item(CMD_STEP, Q_MAX, 32'hffff_ffff);
      send_item(CMD_STEP, Q_MIN, 32'hffff_ffff);
      send_item(CMD_STEP, Q_MIN, 32'h0);
      send_item(CMD_STEP, Q_MAX, 32'h0);
      send_item(CMD_STEP, 32'h0, 32'h1);
      send_item(CMD_STEP, 32'hffff_ffff, 32'h1);
      send_item(CMD_STEP, 32'h0001_8000, 32'h0000_0400);
      send_item(CMD_CLEAR, 32'h0, 32'h0);
      wait_drained();

      // tight limits, extreme gains: integral and output clamp both engage
      configure(Q_MAX, Q_MIN, Q_MAX, 31'h0003_0000, 31'h0005_0000);
      send_item(CMD_STEP, 32'h0002_0000, 32'h0001_0000);
      send_item(CMD_STEP, 32'h0002_0000, 32'h0001_0000);
      send_item(CMD_STEP, 32'h0002_0000, 32'h0001_0000);
      send_item(CMD_STEP, 32'hfffe_0000, 32'h0001_0000);
      send_item(CMD_STEP, 32'hfff0_0000, 32'h0);
      send_item(CMD_STEP, 32'h0000_0001, 32'h0000_0001);
      wait_drained();

      configure(Q_MIN, Q_MAX, Q_MIN, 31'h7fff_ffff, 31'h7fff_ffff);
      send_item(CMD_STEP, Q_MAX, 32'hffff_ffff);
      send_item(CMD_STEP, Q_MIN, 32'h0000_0001);
      send_item(CMD_STEP, Q_MAX, 32'h0000_0001);
      send_item(CMD_STEP, 32'h0, 32'h0);
      wait_drained();

      configure(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h1, 31'h1);
      send_item(CMD_STEP, 32'h0010_0000, 32'h0001_0000);
      send_item(CMD_STEP, 32'hfff0_0000, 32'h0001_0000);
      send_item(CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
      wait_drained();

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         configure(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit());
         recv_gaps = (phase != RAND_PHASES - 1);
         // keep offering during the long result stall so the block backs up
         send_gaps = (phase != RAND_PHASES - 1) && (phase != 2);
         if (phase == 2) begin
            long_hold_due = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            cmd = ($urandom_range(0, 19) == 0) ? CMD_CLEAR : CMD_STEP;
            send_item(cmd, rand_err(), rand_dt());
         end
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/pcc_pkg.sv
sv/pcc_mul.sv
sv/pcc_div.sv
sv/pid_controller_clamped.sv
verif/pid_controller_clamped_test.sv
